// ===== src/ppr_pkg.sv =====
// Shared types and constants for the polygon perimeter rescale block.
// Used by ppr_ctrl, ppr_datapath and polygon_perimeter_rescale.
package ppr_pkg;

   localparam int MAX_NODES   = 16;
   localparam int CNT_W       = $clog2(MAX_NODES + 1);
   localparam int IDX_W       = $clog2(MAX_NODES);
   localparam int SQRT_STEPS  = 33;
   localparam int DIV_STEPS   = 72;
   localparam logic [71:0] QCAP = 72'd1 << 40;

   typedef struct packed {
      logic signed [31:0] orig_x;
      logic signed [31:0] orig_y;
      logic signed [31:0] trans_x;
      logic signed [31:0] trans_y;
      logic               last_node;
   } req_type;

   typedef struct packed {
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic               last_out;
      logic               degenerate;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
   } point_type;

   typedef enum logic [1:0] {
      SEL_NEW_ORIG, SEL_NEW_TRANS, SEL_CLOSE_ORIG, SEL_CLOSE_TRANS
   } edge_sel_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_DISPATCH, ST_E_DIFF, ST_E_MUL, ST_E_LOAD, ST_E_ROOT, ST_E_ACC,
      ST_STORE, ST_CENT_LOAD, ST_CENT_DIV, ST_CENT_WR, ST_V_READ, ST_V_DIFF,
      ST_V_MUL, ST_V_LOAD, ST_V_DIV, ST_V_WR, ST_EMIT
   } state_type;

   typedef struct packed {
      logic         latch;
      edge_sel_type sel;
      logic         axis;
      logic         edge_diff;
      logic         edge_mul;
      logic         edge_load;
      logic         root_step;
      logic         edge_acc;
      logic         store;
      logic         div_load;
      logic         div_cent;
      logic         div_step;
      logic         cent_wr;
      logic         mem_rd;
      logic         vtx_diff;
      logic         vtx_mul;
      logic         res_wr;
      logic         emit;
      logic         k_inc;
      logic         clear;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic zero;
      logic last;
      logic degen;
      logic k_last;
      logic root_done;
      logic div_done;
   } sts_type;

endpackage

// ===== src/ppr_datapath.sv =====
// Datapath: accumulators, vertex store, edge-length root unit and shared divider.
// Depends on ppr_pkg; driven by ppr_ctrl through cmd_type.
module ppr_datapath (
   input  logic             clock,
   input  logic             reset,
   input  ppr_pkg::req_type req,
   input  ppr_pkg::cmd_type cmd,
   output ppr_pkg::sts_type sts,
   output ppr_pkg::rsp_type rsp
);
   import ppr_pkg::*;

   req_type            in_ff;
   point_type          mem [MAX_NODES];
   point_type          rd_ff;
   point_type          first_o_ff, prev_o_ff, first_t_ff, prev_t_ff;
   logic [CNT_W-1:0]   count_ff;
   logic [IDX_W-1:0]   k_ff;
   logic signed [36:0] sum_x_ff, sum_y_ff;
   logic [47:0]        po_ff, pt_ff;
   logic [32:0]        ux_ff, uy_ff;
   logic [64:0]        sx_ff, sy_ff;
   logic [65:0]        rad_ff;
   logic [32:0]        root_ff;
   logic [34:0]        srem_ff;
   logic [5:0]         scnt_ff;
   logic [71:0]        dnum_ff, dq_ff;
   logic [47:0]        dden_ff, drem_ff;
   logic [6:0]         dcnt_ff;
   logic signed [31:0] cx_ff, cy_ff, resx_ff, resy_ff;
   logic [32:0]        dmag_ff [2];
   logic               dneg_ff [2];
   logic [56:0]        plo_ff;

   point_type          ea, eb, in_o, in_t;
   logic signed [32:0] dx, dy, vdx, vdy;
   logic [36:0]        r2;
   logic [34:0]        trial;
   logic [48:0]        q2;
   logic [36:0]        sum_abs;
   logic signed [36:0] sum_sel;
   logic [37:0]        cmag;
   logic [56:0]        phi;
   logic [80:0]        prod;
   logic [40:0]        qr;
   logic signed [41:0] rsum;
   logic signed [31:0] rsat, csel, cval;
   logic               rnd;

   assign in_o = '{x: in_ff.orig_x, y: in_ff.orig_y};
   assign in_t = '{x: in_ff.trans_x, y: in_ff.trans_y};

   always_comb begin
      case (cmd.sel)
         SEL_NEW_ORIG: begin
            ea = in_o;       eb = prev_o_ff;
         end
         SEL_NEW_TRANS: begin
            ea = in_t;       eb = prev_t_ff;
         end
         SEL_CLOSE_ORIG: begin
            ea = first_o_ff; eb = prev_o_ff;
         end
         default: begin
            ea = first_t_ff; eb = prev_t_ff;
         end
      endcase
   end

   assign dx = {ea.x[31], ea.x} - {eb.x[31], eb.x};
   assign dy = {ea.y[31], ea.y} - {eb.y[31], eb.y};

   // one root digit per step
   assign r2    = {srem_ff, rad_ff[65:64]};
   assign trial = {root_ff[32:0], 2'b01};

   // restoring divide step
   assign q2 = {drem_ff, dnum_ff[71]};

   assign sum_sel = cmd.axis ? sum_y_ff : sum_x_ff;
   assign sum_abs = sum_sel[36] ? 37'(-sum_sel) : 37'(sum_sel);
   assign cmag    = {1'b0, sum_abs} + 38'(count_ff >> 1);
   // product in two halves: the low half is registered in ST_V_MUL, the state before the divider load
   assign phi     = 57'(dmag_ff[cmd.axis]) * 57'(po_ff[47:24]);
   assign prod    = {phi, 24'b0} + 81'(plo_ff);
   assign cval    = sum_sel[36] ? -$signed(dq_ff[31:0]) : $signed(dq_ff[31:0]);

   assign vdx = {rd_ff.x[31], rd_ff.x} - {cx_ff[31], cx_ff};
   assign vdy = {rd_ff.y[31], rd_ff.y} - {cy_ff[31], cy_ff};

   assign rnd  = {drem_ff, 1'b0} >= {1'b0, dden_ff};
   assign qr   = (dq_ff >= QCAP) ? QCAP[40:0] : 41'(dq_ff[40:0] + 41'(rnd));
   assign csel = cmd.axis ? cy_ff : cx_ff;
   assign rsum = 42'(csel) + (dneg_ff[cmd.axis] ? -$signed({1'b0, qr}) : $signed({1'b0, qr}));

   always_comb begin
      if (rsum > 42'sd2147483647)       rsat = 32'sh7fffffff;
      else if (rsum < -42'sd2147483648) rsat = 32'sh80000000;
      else                              rsat = rsum[31:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) in_ff <= req;
      if (cmd.edge_diff) begin
         ux_ff <= dx[32] ? 33'(-dx) : 33'(dx);
         uy_ff <= dy[32] ? 33'(-dy) : 33'(dy);
      end
      if (cmd.edge_mul) begin
         sx_ff <= 65'(66'(ux_ff) * 66'(ux_ff));
         sy_ff <= 65'(66'(uy_ff) * 66'(uy_ff));
      end
      if (cmd.edge_load) begin
         rad_ff  <= 66'(sx_ff) + 66'(sy_ff);
         root_ff <= '0;
         srem_ff <= '0;
      end else if (cmd.root_step) begin
         rad_ff <= {rad_ff[63:0], 2'b00};
         if (r2 >= {2'b00, trial}) begin
            srem_ff <= 35'(r2 - {2'b00, trial});
            root_ff <= {root_ff[31:0], 1'b1};
         end else begin
            srem_ff <= r2[34:0];
            root_ff <= {root_ff[31:0], 1'b0};
         end
      end
      if (cmd.store) mem[count_ff[IDX_W-1:0]] <= in_t;
      if (cmd.mem_rd) rd_ff <= mem[k_ff];
      if (cmd.vtx_mul) plo_ff <= 57'(dmag_ff[cmd.axis]) * 57'(po_ff[23:0]);
      if (cmd.div_load) begin
         dnum_ff <= cmd.div_cent ? 72'(cmag) : prod[71:0];
         dden_ff <= cmd.div_cent ? 48'(count_ff) : pt_ff;
         drem_ff <= '0;
         dq_ff   <= '0;
      end else if (cmd.div_step) begin
         dnum_ff <= {dnum_ff[70:0], 1'b0};
         dq_ff   <= {dq_ff[70:0], (q2 >= {1'b0, dden_ff})};
         drem_ff <= (q2 >= {1'b0, dden_ff}) ? 48'(q2 - {1'b0, dden_ff}) : q2[47:0];
      end
      if (cmd.cent_wr) begin
         if (cmd.axis) cy_ff <= cval;
         else          cx_ff <= cval;
      end
      if (cmd.vtx_diff) begin
         dmag_ff[0] <= vdx[32] ? 33'(-vdx) : 33'(vdx);
         dmag_ff[1] <= vdy[32] ? 33'(-vdy) : 33'(vdy);
         dneg_ff[0] <= vdx[32];
         dneg_ff[1] <= vdy[32];
      end
      if (cmd.res_wr) begin
         if (cmd.axis) resy_ff <= rsat;
         else          resx_ff <= rsat;
      end
   end

   // control-side state: counters, accumulators and first/previous vertices
   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         count_ff   <= '0;
         k_ff       <= '0;
         sum_x_ff   <= '0;
         sum_y_ff   <= '0;
         po_ff      <= '0;
         pt_ff      <= '0;
         first_o_ff <= '0;
         prev_o_ff  <= '0;
         first_t_ff <= '0;
         prev_t_ff  <= '0;
         scnt_ff    <= '0;
         dcnt_ff    <= '0;
      end else begin
         if (cmd.edge_load)      scnt_ff <= '0;
         else if (cmd.root_step) scnt_ff <= scnt_ff + 6'd1;
         if (cmd.div_load)       dcnt_ff <= '0;
         else if (cmd.div_step)  dcnt_ff <= dcnt_ff + 7'd1;
         if (cmd.edge_acc) begin
            if (cmd.sel == SEL_NEW_ORIG || cmd.sel == SEL_CLOSE_ORIG)
               po_ff <= po_ff + 48'(root_ff);
            else
               pt_ff <= pt_ff + 48'(root_ff);
         end
         if (cmd.store) begin
            if (count_ff == '0) begin
               first_o_ff <= in_o;
               first_t_ff <= in_t;
            end
            prev_o_ff <= in_o;
            prev_t_ff <= in_t;
            sum_x_ff  <= sum_x_ff + 37'(in_ff.orig_x);
            sum_y_ff  <= sum_y_ff + 37'(in_ff.orig_y);
            count_ff  <= count_ff + CNT_W'(1);
         end
         if (cmd.k_inc) k_ff <= k_ff + IDX_W'(1);
      end
   end

   assign sts.full      = (count_ff == CNT_W'(MAX_NODES));
   assign sts.zero      = (count_ff == '0);
   assign sts.last      = in_ff.last_node;
   assign sts.degen     = (pt_ff == '0);
   assign sts.k_last    = ({1'b0, k_ff} == count_ff - CNT_W'(1));
   assign sts.root_done = (scnt_ff == 6'(SQRT_STEPS));
   assign sts.div_done  = (dcnt_ff == 7'(DIV_STEPS));

   assign rsp.out_x      = sts.degen ? rd_ff.x : resx_ff;
   assign rsp.out_y      = sts.degen ? rd_ff.y : resy_ff;
   assign rsp.last_out   = sts.k_last;
   assign rsp.degenerate = sts.degen;

endmodule

// ===== src/ppr_ctrl.sv =====
// Controller state machine: sequences edge roots, centroid and rescale divides.
// Depends on ppr_pkg; commands ppr_datapath.
module ppr_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  ppr_pkg::sts_type sts,
   output ppr_pkg::cmd_type cmd,
   output logic             busy
);
   import ppr_pkg::*;

   state_type    state_ff, state_in;
   edge_sel_type sel_ff, sel_in;
   logic         axis_ff, axis_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sel_ff   <= SEL_NEW_ORIG;
         axis_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
         axis_ff  <= axis_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      sel_in   = sel_ff;
      axis_in  = axis_ff;
      cmd      = '0;
      cmd.sel  = sel_ff;
      cmd.axis = axis_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.latch = 1'b1;
               state_in  = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            if (!sts.full) begin
               if (sts.zero) state_in = ST_STORE;
               else begin
                  sel_in   = SEL_NEW_ORIG;
                  state_in = ST_E_DIFF;
               end
            end else if (sts.last) begin
               sel_in   = SEL_CLOSE_ORIG;
               state_in = ST_E_DIFF;
            end else state_in = ST_IDLE;
         end
         ST_E_DIFF: begin
            cmd.edge_diff = 1'b1;
            state_in      = ST_E_MUL;
         end
         ST_E_MUL: begin
            cmd.edge_mul = 1'b1;
            state_in     = ST_E_LOAD;
         end
         ST_E_LOAD: begin
            cmd.edge_load = 1'b1;
            state_in      = ST_E_ROOT;
         end
         ST_E_ROOT: begin
            if (sts.root_done) state_in = ST_E_ACC;
            else cmd.root_step = 1'b1;
         end
         ST_E_ACC: begin
            cmd.edge_acc = 1'b1;
            case (sel_ff)
               SEL_NEW_ORIG: begin
                  sel_in   = SEL_NEW_TRANS;
                  state_in = ST_E_DIFF;
               end
               SEL_NEW_TRANS:  state_in = ST_STORE;
               SEL_CLOSE_ORIG: begin
                  sel_in   = SEL_CLOSE_TRANS;
                  state_in = ST_E_DIFF;
               end
               default: begin
                  axis_in  = 1'b0;
                  state_in = ST_CENT_LOAD;
               end
            endcase
         end
         ST_STORE: begin
            cmd.store = 1'b1;
            if (sts.last) begin
               sel_in   = SEL_CLOSE_ORIG;
               state_in = ST_E_DIFF;
            end else state_in = ST_IDLE;
         end
         ST_CENT_LOAD: begin
            cmd.div_load = 1'b1;
            cmd.div_cent = 1'b1;
            state_in     = ST_CENT_DIV;
         end
         ST_CENT_DIV: begin
            if (sts.div_done) state_in = ST_CENT_WR;
            else cmd.div_step = 1'b1;
         end
         ST_CENT_WR: begin
            cmd.cent_wr = 1'b1;
            axis_in     = ~axis_ff;
            state_in    = axis_ff ? ST_V_READ : ST_CENT_LOAD;
         end
         ST_V_READ: begin
            cmd.mem_rd = 1'b1;
            state_in   = ST_V_DIFF;
         end
         ST_V_DIFF: begin
            cmd.vtx_diff = 1'b1;
            axis_in      = 1'b0;
            state_in     = sts.degen ? ST_EMIT : ST_V_MUL;
         end
         ST_V_MUL: begin
            cmd.vtx_mul = 1'b1;
            state_in    = ST_V_LOAD;
         end
         ST_V_LOAD: begin
            cmd.div_load = 1'b1;
            state_in     = ST_V_DIV;
         end
         ST_V_DIV: begin
            if (sts.div_done) state_in = ST_V_WR;
            else cmd.div_step = 1'b1;
         end
         ST_V_WR: begin
            cmd.res_wr = 1'b1;
            axis_in    = ~axis_ff;
            state_in   = axis_ff ? ST_EMIT : ST_V_MUL;
         end
         ST_EMIT: begin
            cmd.emit = 1'b1;
            if (sts.k_last) begin
               cmd.clear = 1'b1;
               state_in  = ST_IDLE;
            end else begin
               cmd.k_inc = 1'b1;
               state_in  = ST_V_READ;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

   // a result strobe is never held: ST_EMIT always moves on to ST_V_READ or ST_IDLE
   a_emit_single: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> !cmd.emit) else $error("result strobe held");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("transfer not taken up");

   a_root_leave: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_E_ROOT && sts.root_done) |=> state_ff == ST_E_ACC)
      else $error("root unit finish missed");

endmodule

// ===== src/polygon_perimeter_rescale.sv =====
// Top level of the polygon perimeter rescale block.
// Depends on ppr_pkg, ppr_ctrl and ppr_datapath.
//
//   channel | ports                  | transfer
//   --------+------------------------+------------------------------
//   input   | start, busy, req_data  | start high while busy low
//   result  | rsp_valid, rsp_data    | every cycle rsp_valid is high
//
// Each stored vertex after the first runs the original and transformed edge roots between
// dispatch and store; the first vertex of a polygon goes straight to store.
// The last vertex adds two closing roots and two centroid divides, then
// each stored vertex is read, differenced and rescaled by two divides (one per axis,
// each with multiply, load and write) before its strobe; degenerate polygons skip them.
// Reset is synchronous and clears all counters and sums; the vertex store is not
// cleared. Results cannot be stalled.
module polygon_perimeter_rescale (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  ppr_pkg::req_type req_data,
   output logic             rsp_valid,
   output ppr_pkg::rsp_type rsp_data
);
   import ppr_pkg::*;

   cmd_type cmd;
   sts_type sts;

   ppr_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .sts   (sts),
      .cmd   (cmd),
      .busy  (busy)
   );

   ppr_datapath u_datapath (
      .clock (clock),
      .reset (reset),
      .req   (req_data),
      .cmd   (cmd),
      .sts   (sts),
      .rsp   (rsp_data)
   );

   assign rsp_valid = cmd.emit;

endmodule

// ===== dv/polygon_perimeter_rescale_test.sv =====
// Self-checking testbench for polygon_perimeter_rescale: vertex streams in, rescaled vertices out.
// Depends on ppr_pkg and the polygon_perimeter_rescale RTL; predicts results bit for bit.
module polygon_perimeter_rescale_test;
   import ppr_pkg::*;

   localparam int NODE_LIMIT = MAX_NODES;
   localparam longint CYCLE_LIMIT = 64'd3_000_000;

   logic    clock, reset, start, busy, rsp_valid;
   req_type req;
   rsp_type rsp;

   polygon_perimeter_rescale uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req), .rsp_valid(rsp_valid), .rsp_data(rsp)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // predictor state
   logic [63:0]  tstore [NODE_LIMIT];
   int           nstored;
   logic signed [63:0] sum_x, sum_y;
   logic [63:0]  per_orig, per_trans;
   logic [63:0]  first_o, prev_o, first_t, prev_t;

   req_type      vertex_queue[$];
   rsp_type      rescaled_queue[$];
   int           errors, polygons_sent, vertices_emitted;
   longint       cycles;

   function automatic logic [63:0] pack_point(logic signed [31:0] x, logic signed [31:0] y);
      return {x, y};
   endfunction

   function automatic logic [63:0] edge_length(logic [63:0] a, logic [63:0] b);
      logic signed [63:0] dx, dy;
      logic [65:0] sq, rem, trial;
      logic [63:0] root;
      dx = 64'($signed(a[63:32])) - 64'($signed(b[63:32]));
      dy = 64'($signed(a[31:0])) - 64'($signed(b[31:0]));
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      sq = 66'(dx) * 66'(dx) + 66'(dy) * 66'(dy);
      root = 0;
      rem = 0;
      for (int k = 32; k >= 0; k--) begin
         rem = (rem << 2) | 66'(sq[2*k +: 2]);
         trial = 66'({root, 2'b01});
         if (rem >= trial) begin
            rem = rem - trial;
            root = {root[62:0], 1'b1};
         end else begin
            root = {root[62:0], 1'b0};
         end
      end
      return root;
   endfunction

   function automatic logic signed [63:0] centre(logic signed [63:0] s, int n);
      logic [63:0] mag, q;
      mag = (s < 0) ? 64'(-s) : 64'(s);
      q = (mag + 64'(n / 2)) / 64'(n);
      return (s < 0) ? -$signed(q) : $signed(q);
   endfunction

   function automatic logic [63:0] scaled_offset(logic [63:0] mag, logic [63:0] po,
                                                 logic [63:0] pt);
      logic [127:0] prod;
      logic [63:0]  q, rem;
      logic [64:0]  wide;
      prod = 128'(mag) * 128'(po);
      q = 0;
      rem = 0;
      for (int i = 127; i >= 0; i--) begin
         wide = {rem, prod[i]};
         q = q << 1;
         if (wide >= 65'(pt)) begin
            wide = wide - 65'(pt);
            q[0] = 1'b1;
         end
         rem = wide[63:0];
         if (q > (64'd1 << 40)) q = 64'd1 << 40;
      end
      if ((65'(rem) << 1) >= 65'(pt) && q < (64'd1 << 40)) q++;
      return q;
   endfunction

   function automatic logic signed [31:0] saturate(logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   task automatic predict_vertex(req_type r);
      logic [63:0] op, tp, q;
      logic signed [63:0] cx, cy, c, d, res;
      rsp_type e;
      logic degen;
      op = pack_point(r.orig_x, r.orig_y);
      tp = pack_point(r.trans_x, r.trans_y);
      if (nstored < NODE_LIMIT) begin
         if (nstored == 0) begin
            first_o = op;
            first_t = tp;
         end else begin
            per_orig += edge_length(op, prev_o);
            per_trans += edge_length(tp, prev_t);
         end
         prev_o = op;
         prev_t = tp;
         sum_x += 64'(r.orig_x);
         sum_y += 64'(r.orig_y);
         tstore[nstored] = tp;
         nstored++;
      end
      if (!r.last_node) return;
      per_orig += edge_length(first_o, prev_o);
      per_trans += edge_length(first_t, prev_t);
      cx = centre(sum_x, nstored);
      cy = centre(sum_y, nstored);
      degen = (per_trans == 0);
      for (int k = 0; k < nstored; k++) begin
         for (int j = 0; j < 2; j++) begin
            res = (j == 0) ? 64'($signed(tstore[k][63:32])) : 64'($signed(tstore[k][31:0]));
            if (!degen) begin
               c = (j == 0) ? cx : cy;
               d = res - c;
               q = scaled_offset((d < 0) ? 64'(-d) : 64'(d), per_orig, per_trans);
               res = c + ((d < 0) ? -$signed(q) : $signed(q));
            end
            if (j == 0) e.out_x = saturate(res);
            else e.out_y = saturate(res);
         end
         e.last_out = (k + 1 == nstored);
         e.degenerate = degen;
         rescaled_queue.push_back(e);
      end
      nstored = 0;
      sum_x = 0;
      sum_y = 0;
      per_orig = 0;
      per_trans = 0;
      first_o = 0;
      prev_o = 0;
      first_t = 0;
      prev_t = 0;
   endtask

   function automatic logic [31:0] rand_coord(int mode);
      case (mode)
         0: return $urandom;
         1: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
         2: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
         default: return 32'($signed($urandom_range(0, 400)) - 200) <<< 16;
      endcase
   endfunction

   task automatic add_vertex(logic [31:0] ox, oy, tx, ty, logic last);
      req_type r;
      r.orig_x = ox;
      r.orig_y = oy;
      r.trans_x = tx;
      r.trans_y = ty;
      r.last_node = last;
      vertex_queue.push_back(r);
      if (last) polygons_sent++;
   endtask

   task automatic add_polygon(int n, int mode);
      logic [31:0] sx, sy, ox, oy;
      int shrink;
      shrink = $urandom_range(0, 3);
      for (int i = 0; i < n; i++) begin
         ox = rand_coord(mode);
         oy = rand_coord(mode);
         if (mode == 3 && shrink == 0) begin
            // keep the transformed shape close to the original
            sx = ox + 32'($signed($urandom_range(0, 8000)) - 4000);
            sy = oy + 32'($signed($urandom_range(0, 8000)) - 4000);
         end else begin
            sx = rand_coord(mode);
            sy = rand_coord(mode);
         end
         add_vertex(ox, oy, sx, sy, i == n - 1);
      end
   endtask

   // driver: bursts with random gaps; inputs change on the falling edge
   int gap_left, burst_left;
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && !busy) begin
         // current vertex has been taken and the block is idle again; present the next vertex or drop start
         if (vertex_queue.size() != 0 && burst_left > 0) begin
            req <= vertex_queue.pop_front();
            burst_left <= burst_left - 1;
         end else begin
            start <= 1'b0;
            gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40);
         end
      end else if (!start) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
         end else if (vertex_queue.size() != 0) begin
            req <= vertex_queue.pop_front();
            start <= 1'b1;
            burst_left <= $urandom_range(0, 12);
         end
      end
   end

   // monitor and predictor hook, sampled at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         cycles++;
         if (start && !busy) predict_vertex(req);
         if (rsp_valid) begin
            vertices_emitted++;
            if (rescaled_queue.size() == 0) begin
               $display("%0t: unexpected result x=%h y=%h last=%b degen=%b", $time,
                        rsp.out_x, rsp.out_y, rsp.last_out, rsp.degenerate);
               errors++;
            end else begin
               rsp_type e;
               e = rescaled_queue.pop_front();
               if (rsp.out_x !== e.out_x)
                  $display("%0t: out_x expected %h actual %h", $time, e.out_x, rsp.out_x);
               if (rsp.out_y !== e.out_y)
                  $display("%0t: out_y expected %h actual %h", $time, e.out_y, rsp.out_y);
               if (rsp.last_out !== e.last_out)
                  $display("%0t: last_out expected %b actual %b", $time, e.last_out,
                           rsp.last_out);
               if (rsp.degenerate !== e.degenerate)
                  $display("%0t: degenerate expected %b actual %b", $time, e.degenerate,
                           rsp.degenerate);
               if (rsp !== e) errors++;
            end
         end
         if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d vertices pending", $time, rescaled_queue.size());
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   initial begin
      int n, done_wait;
      reset = 1'b1;
      start = 1'b0;
      req = '0;
      gap_left = 0;
      burst_left = 0;
      errors = 0;
      cycles = 0;
      polygons_sent = 0;
      vertices_emitted = 0;
      nstored = 0;
      sum_x = 0;
      sum_y = 0;
      per_orig = 0;
      per_trans = 0;
      first_o = 0;
      prev_o = 0;
      first_t = 0;
      prev_t = 0;

      // directed: single vertex (degenerate), extremes, zero-perimeter triangle, overflow
      add_vertex(32'h7fffffff, 32'h80000000, 32'h12345678, 32'hfedcba98, 1'b1);
      add_vertex(32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 1'b0);
      add_vertex(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 1'b1);
      add_vertex(32'h00010000, 32'h0, 32'h00050000, 32'h00050000, 1'b0);
      add_vertex(32'h0, 32'h00010000, 32'h00050000, 32'h00050000, 1'b0);
      add_vertex(32'hffff0000, 32'h0, 32'h00050000, 32'h00050000, 1'b1);
      add_vertex(32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
      add_vertex(32'h00100000, 32'h0, 32'h00000001, 32'h0, 1'b0);
      add_vertex(32'h0, 32'h00100000, 32'h0, 32'h00000001, 1'b1);
      // sixteen vertices and more: extras are ignored, the last still closes
      add_polygon(19, 3);
      add_polygon(16, 1);
      add_polygon(17, 2);

      while (polygons_sent < 59) begin
         n = $urandom_range(0, 9) == 0 ? $urandom_range(17, 20) : $urandom_range(1, 8);
         add_polygon(n, $urandom_range(0, 3));
      end

      repeat (4) @(posedge clock);
      @(negedge clock) reset = 1'b0;

      wait (vertex_queue.size() == 0 && !start);
      wait (rescaled_queue.size() == 0);
      done_wait = 0;
      while (done_wait < 400) begin
         @(posedge clock);
         done_wait++;
      end
      $display("Checked %0d rescaled vertices from %0d polygons (degenerate, overfull,",
               vertices_emitted, polygons_sent);
      $display("saturating and random shapes) under bursty input.");
      if (errors == 0 && rescaled_queue.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule

// ===== sim.f =====
src/ppr_pkg.sv
src/ppr_datapath.sv
src/ppr_ctrl.sv
src/polygon_perimeter_rescale.sv
dv/polygon_perimeter_rescale_test.sv
